// File: sv/pirt_pkg.sv
`timescale 1ns / 1ps

package pirt_pkg;

  localparam int NumRecords = 20;
  localparam int RecIdxW    = 5;
  localparam int CoordW     = 16;
  localparam int DiffW      = CoordW + 1;
  localparam int ScalarInW  = 35;
  localparam int ScalarW    = 34;
  localparam int WideW      = 35;
  localparam int SqW        = 70;

  localparam int RecCyl0    = 3;
  localparam int RecPlane0  = 15;
  localparam int NumPlanes  = 5;

  typedef enum logic {
    ActLoad = 1'b0,
    ActTest = 1'b1
  } action_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [DiffW-1:0] x;
    logic signed [DiffW-1:0] y;
    logic signed [DiffW-1:0] z;
  } diff_t;

  // exact square of a signed 35-bit value from three narrow partial products
  function automatic logic [SqW-1:0] sq_mag(input logic signed [WideW-1:0] v);
    logic [WideW-1:0] m;
    logic [17:0]      hi;
    logic [16:0]      lo;
    logic [35:0]      phh;
    logic [34:0]      phl;
    logic [33:0]      pll;
    m   = v[WideW-1] ? WideW'(-v) : WideW'(v);
    hi  = m[34:17];
    lo  = m[16:0];
    phh = 36'(hi) * 36'(hi);
    phl = 35'(hi) * 35'(lo);
    pll = 34'(lo) * 34'(lo);
    return (SqW'(phh) << 34) + (SqW'(phl) << 18) + SqW'(pll);
  endfunction

  function automatic diff_t vsub(input vec_t a, input vec_t b);
    diff_t r;
    r.x = DiffW'(a.x) - DiffW'(b.x);
    r.y = DiffW'(a.y) - DiffW'(b.y);
    r.z = DiffW'(a.z) - DiffW'(b.z);
    return r;
  endfunction

endpackage

// File: sv/point_in_rounded_triangle_unit.sv
`timescale 1ns / 1ps
// A test transfer's valid bit passes through v1_q to v5_q, and its result shows on valid_o from out_valid_q.
// Throughput: one test point per cycle while valid_o is not stalled; the pipeline holds as one while valid_o stalls.
// A load is taken only when no test is in flight, and gives no result.
// Reset (rst_ni low, async) clears the shape table and all valid bits.

module point_in_rounded_triangle_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic                                  action_i,
  input  logic [pirt_pkg::RecIdxW-1:0]          record_index_i,
  input  logic signed [pirt_pkg::CoordW-1:0]    ax_i,
  input  logic signed [pirt_pkg::CoordW-1:0]    ay_i,
  input  logic signed [pirt_pkg::CoordW-1:0]    az_i,
  input  logic signed [pirt_pkg::ScalarInW-1:0] scalar_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic                                  inside_res_o
);

  pirt_pkg::vec_t                       vec_q [pirt_pkg::NumRecords];
  logic signed [pirt_pkg::ScalarW-1:0]  scl_q [pirt_pkg::NumRecords];

  logic advance, busy, in_xfer, test_in, load_in;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q, inside_q;
  pirt_pkg::vec_t p1_q, p2_q, p_in;
  logic signed [pirt_pkg::ScalarW-1:0] sat_s;

  logic signed [31:0] pp_q [pirt_pkg::NumPlanes][3];
  logic [pirt_pkg::NumPlanes-1:0] pl_ok_d;
  logic plane_ok_q, plane_ok2_q;
  logic [2:0] sph_hit, cyl_hit;

  assign p_in    = '{x: ax_i, y: ay_i, z: az_i};
  assign advance = !out_valid_q || !stall_i;
  assign busy    = v1_q | v2_q | v3_q | v4_q | v5_q | out_valid_q;
  assign stall_o = (action_i == pirt_pkg::ActTest) ? !advance : busy;
  assign in_xfer = valid_i && !stall_o;
  assign test_in = in_xfer && (action_i == pirt_pkg::ActTest);
  assign load_in = in_xfer && (action_i == pirt_pkg::ActLoad);

  always_comb begin
    if (scalar_i[34] != scalar_i[33]) begin
      sat_s = scalar_i[34] ? {1'b1, {(pirt_pkg::ScalarW-1){1'b0}}}
                           : {1'b0, {(pirt_pkg::ScalarW-1){1'b1}}};
    end else begin
      sat_s = scalar_i[pirt_pkg::ScalarW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < pirt_pkg::NumRecords; r++) begin
        vec_q[r] <= '0;
        scl_q[r] <= '0;
      end
    end else if (load_in && (record_index_i < pirt_pkg::RecIdxW'(pirt_pkg::NumRecords))) begin
      vec_q[record_index_i] <= p_in;
      scl_q[record_index_i] <= sat_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= test_in;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  always_comb begin
    for (int k = 0; k < pirt_pkg::NumPlanes; k++) begin
      pl_ok_d[k] = (36'(pp_q[k][0]) + 36'(pp_q[k][1]) + 36'(pp_q[k][2])
                   + 36'(scl_q[pirt_pkg::RecPlane0 + k])) >= 0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p1_q <= p_in;
      p2_q <= p1_q;
      for (int k = 0; k < pirt_pkg::NumPlanes; k++) begin
        pp_q[k][0] <= 32'(p2_q.x) * 32'(vec_q[pirt_pkg::RecPlane0 + k].x);
        pp_q[k][1] <= 32'(p2_q.y) * 32'(vec_q[pirt_pkg::RecPlane0 + k].y);
        pp_q[k][2] <= 32'(p2_q.z) * 32'(vec_q[pirt_pkg::RecPlane0 + k].z);
      end
      plane_ok_q  <= &pl_ok_d;
      plane_ok2_q <= plane_ok_q;
      inside_q    <= (|sph_hit) | (|cyl_hit) | plane_ok2_q;
    end
  end

  for (genvar s = 0; s < 3; s++) begin : g_sph
    pirt_sphere u_sph (
      .clk_i (clk_i),
      .en_i  (advance),
      .p_i   (p1_q),
      .ctr_i (vec_q[s]),
      .rad_i (scl_q[s]),
      .hit_o (sph_hit[s])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_cyl
    localparam int Base = pirt_pkg::RecCyl0 + 4 * c;
    pirt_cyl u_cyl (
      .clk_i  (clk_i),
      .en_i   (advance),
      .p_i    (p1_q),
      .org_i  (vec_q[Base]),
      .rr_i   (scl_q[Base]),
      .r0_i   (vec_q[Base + 1]),
      .hh_i   (scl_q[Base + 1]),
      .r1_i   (vec_q[Base + 2]),
      .axis_i (vec_q[Base + 3]),
      .hit_o  (cyl_hit[c])
    );
  end

  assign valid_o      = out_valid_q;
  assign inside_res_o = inside_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && v5_q) |=> out_valid_q)
    else $error("last stage lost its item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable({v1_q, v2_q, v3_q, v4_q, v5_q}))
    else $error("pipeline moved while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> ($stable(vec_q[15]) && $stable(scl_q[3]) && $stable(scl_q[0])))
    else $error("shape table changed with tests in flight");

endmodule

// File: sv/pirt_sphere.sv
`timescale 1ns / 1ps

module pirt_sphere (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  pirt_pkg::vec_t                      p_i,
  input  pirt_pkg::vec_t                      ctr_i,
  input  logic signed [pirt_pkg::ScalarW-1:0] rad_i,
  output logic                                hit_o
);

  pirt_pkg::diff_t               d_q;
  logic [33:0]                   sqx_q, sqy_q, sqz_q;
  logic [pirt_pkg::SqW-1:0]      r2_q, r2b_q;
  logic [35:0]                   dd_q;
  logic                          hit_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q   <= pirt_pkg::vsub(p_i, ctr_i);
      sqx_q <= 34'($signed(34'(d_q.x)) * $signed(34'(d_q.x)));
      sqy_q <= 34'($signed(34'(d_q.y)) * $signed(34'(d_q.y)));
      sqz_q <= 34'($signed(34'(d_q.z)) * $signed(34'(d_q.z)));
      r2_q  <= pirt_pkg::sq_mag(pirt_pkg::WideW'(rad_i));
      dd_q  <= 36'(sqx_q) + 36'(sqy_q) + 36'(sqz_q);
      r2b_q <= r2_q;
      hit_q <= pirt_pkg::SqW'(dd_q) <= r2b_q;
    end
  end

  assign hit_o = hit_q;

endmodule

// File: sv/pirt_cyl.sv
`timescale 1ns / 1ps

module pirt_cyl (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  pirt_pkg::vec_t                      p_i,
  input  pirt_pkg::vec_t                      org_i,
  input  logic signed [pirt_pkg::ScalarW-1:0] rr_i,
  input  pirt_pkg::vec_t                      r0_i,
  input  logic signed [pirt_pkg::ScalarW-1:0] hh_i,
  input  pirt_pkg::vec_t                      r1_i,
  input  pirt_pkg::vec_t                      axis_i,
  output logic                                hit_o
);

  pirt_pkg::diff_t                      d_q;
  logic signed [32:0]                   pr0_q [3];
  logic signed [32:0]                   pr1_q [3];
  logic signed [32:0]                   prh_q [3];
  logic [pirt_pkg::SqW-1:0]             rr2_q, rr2b_q, rr2c_q;
  logic signed [pirt_pkg::WideW-1:0]    c0_q, c1_q, ch_d;
  logic                                 ok_d, ok_q, ok2_q;
  logic [pirt_pkg::SqW-1:0]             c0sq_q, c1sq_q;
  logic signed [pirt_pkg::WideW-1:0]    hh_w;

  function automatic logic signed [32:0] mul(input logic signed [pirt_pkg::DiffW-1:0] a,
                                             input logic signed [pirt_pkg::CoordW-1:0] b);
    return 33'(a) * 33'(b);
  endfunction

  assign ch_d = pirt_pkg::WideW'(prh_q[0]) + pirt_pkg::WideW'(prh_q[1])
              + pirt_pkg::WideW'(prh_q[2]);
  assign hh_w = pirt_pkg::WideW'(hh_i);

  always_comb begin
    if (rr_i == '0 || hh_i == '0) begin
      ok_d = 1'b0;
    end else if (hh_i > 0) begin
      ok_d = (ch_d >= 0) && (ch_d <= hh_w);
    end else begin
      ok_d = (ch_d <= 0) && (ch_d >= hh_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q      <= pirt_pkg::vsub(p_i, org_i);
      pr0_q[0] <= mul(d_q.x, r0_i.x);
      pr0_q[1] <= mul(d_q.y, r0_i.y);
      pr0_q[2] <= mul(d_q.z, r0_i.z);
      pr1_q[0] <= mul(d_q.x, r1_i.x);
      pr1_q[1] <= mul(d_q.y, r1_i.y);
      pr1_q[2] <= mul(d_q.z, r1_i.z);
      prh_q[0] <= mul(d_q.x, axis_i.x);
      prh_q[1] <= mul(d_q.y, axis_i.y);
      prh_q[2] <= mul(d_q.z, axis_i.z);
      rr2_q    <= pirt_pkg::sq_mag(pirt_pkg::WideW'(rr_i));
      c0_q     <= pirt_pkg::WideW'(pr0_q[0]) + pirt_pkg::WideW'(pr0_q[1])
                + pirt_pkg::WideW'(pr0_q[2]);
      c1_q     <= pirt_pkg::WideW'(pr1_q[0]) + pirt_pkg::WideW'(pr1_q[1])
                + pirt_pkg::WideW'(pr1_q[2]);
      ok_q     <= ok_d;
      rr2b_q   <= rr2_q;
      c0sq_q   <= pirt_pkg::sq_mag(c0_q);
      c1sq_q   <= pirt_pkg::sq_mag(c1_q);
      ok2_q    <= ok_q;
      rr2c_q   <= rr2b_q;
    end
  end

  assign hit_o = ok2_q &&
                 ((71'(c0sq_q) + 71'(c1sq_q)) <= 71'(rr2c_q));

endmodule
